// File: design/ccd_pkg.sv
// Package for the ChaCha permutation random byte generator.
// Holds payload structs, command codes, sequencer states and constants.
package ccd_pkg;

   typedef enum logic [1:0] {
      CMD_SEED     = 2'd0,
      CMD_ENTROPY  = 2'd1,
      CMD_GENERATE = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] timestamp;
      logic [31:0] tick_count;
      logic [7:0]  entropy_byte;
      logic        last_entropy;
      logic [6:0]  byte_count;
      logic        fresh_request;
   } req_type;

   typedef struct packed {
      logic [7:0] random_byte;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_PREP,
      ST_ROUND,
      ST_EMIT,
      ST_FOLD
   } state_type;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;
   localparam logic [31:0] GOLDEN = 32'h9E3779B9;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
      rotl32 = (x << n) | (x >> (32 - n));
   endfunction

endpackage

// File: design/chacha_permutation_drbg_unit.sv
// Top level of the ChaCha permutation random byte generator.
// Seed, also run first by an unseeded generate, fills the state from the timestamp and
// the constants; a pool fold XORs the pool into the state. Generate runs prep, then the
// rounds on one shared quarter-round unit, then a byte per cycle while rsp_ready is high.
// Synchronous active-high reset clears state, pool, counters and sets the interval to 256.
module chacha_permutation_drbg_unit
   import ccd_pkg::*;
#(
   parameter int DOUBLE_ROUNDS = 10
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [8:0] csr_data
);
   localparam int RW = $clog2(DOUBLE_ROUNDS * 8 + 1);

   state_type   state_ff, state_in;
   logic [31:0] words_ff [16];
   logic [31:0] words_in [16];
   logic [31:0] pool_ff [16];
   logic [31:0] pool_in [16];
   logic [31:0] count_ff, count_in;
   logic        seeded_ff, seeded_in;
   logic [5:0]  pos_ff, pos_in;
   logic [8:0]  writes_ff, writes_in;
   logic [8:0]  interval_ff;
   req_type     item_ff, item_in;
   logic [63:0] ts_ff, ts_in;
   logic [3:0]  step_ff, step_in;
   logic [RW-1:0] round_ff, round_in;
   logic [6:0]  total_ff, total_in;
   logic [5:0]  emit_ff, emit_in;

   logic [3:0]  ia, ib, ic, id;
   logic [31:0] qa, qb, qc, qd;
   logic [63:0] mix;
   logic [6:0]  sat;

   always_comb begin
      unique case (round_ff[2:0])
         3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
         3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
         3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
         3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
         3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
         3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
         3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
         default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
      endcase
   end

   ccd_quarter u_quarter (
      .a_in(words_ff[ia]), .b_in(words_ff[ib]), .c_in(words_ff[ic]), .d_in(words_ff[id]),
      .a_out(qa), .b_out(qb), .c_out(qc), .d_out(qd)
   );

   assign mix = (ts_ff ^ {item_ff.tick_count, 32'd0})
              + {32'd0, {28'd0, step_ff} * GOLDEN};
   assign sat = (req_data.byte_count > 7'd64) ? 7'd64 : req_data.byte_count;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (cmd_type'(req_data.cmd))
                  CMD_SEED: state_in = ST_SEED;
                  CMD_ENTROPY: begin
                     if (req_data.last_entropy
                         && ((writes_ff + 9'd1) >= interval_ff))
                        state_in = ST_FOLD;
                  end
                  CMD_GENERATE: begin
                     if (req_data.byte_count != 7'd0)
                        state_in = seeded_ff ? ST_PREP : ST_SEED;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEED: begin
            if (step_ff == 4'd15)
               state_in = (cmd_type'(item_ff.cmd) == CMD_GENERATE) ? ST_PREP : ST_IDLE;
         end
         ST_PREP: state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == RW'(DOUBLE_ROUNDS * 8 - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready && ({1'b0, emit_ff} + 7'd1 == total_ff)) state_in = ST_IDLE;
         end
         ST_FOLD: begin
            if (step_ff == 4'd15) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      rsp_data.random_byte = words_ff[emit_ff[5:2]][emit_ff[1:0]*8 +: 8];
      rsp_data.last = ({1'b0, emit_ff} + 7'd1 == total_ff);
   end

   always_comb begin
      words_in = words_ff;
      pool_in = pool_ff;
      count_in = count_ff;
      seeded_in = seeded_ff;
      pos_in = pos_ff;
      writes_in = writes_ff;
      item_in = item_ff;
      ts_in = ts_ff;
      step_in = step_ff;
      round_in = round_ff;
      total_in = total_ff;
      emit_in = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            item_in = req_data;
            ts_in = req_data.timestamp;
            step_in = 4'd4;
            round_in = '0;
            emit_in = '0;
            total_in = sat;
            if (req_valid && cmd_type'(req_data.cmd) == CMD_ENTROPY) begin
               pool_in[pos_ff[5:2]][pos_ff[1:0]*8 +: 8] =
                  pool_ff[pos_ff[5:2]][pos_ff[1:0]*8 +: 8] ^ req_data.entropy_byte;
               pos_in = pos_ff + 6'd1;
               step_in = 4'd0;
               if (req_data.last_entropy) begin
                  writes_in = writes_ff + 9'd1;
                  if ((writes_ff + 9'd1) >= interval_ff) writes_in = '0;
               end
            end
         end
         ST_SEED: begin
            words_in[step_ff] = mix[31:0] ^ mix[63:32];
            ts_in = ts_ff ^ {mix[50:0], mix[63:51]};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               words_in[0] = SIGMA0;
               words_in[1] = SIGMA1;
               words_in[2] = SIGMA2;
               words_in[3] = SIGMA3;
               count_in = 32'd1;
               seeded_in = 1'b1;
               pos_in = '0;
               writes_in = '0;
               for (int i = 0; i < 16; i++) pool_in[i] = 32'd0;
               pool_in[0] = ts_in[31:0];
               pool_in[1] = ts_in[63:32];
            end
         end
         ST_PREP: begin
            if (item_ff.fresh_request) begin
               words_in[13] = words_ff[13] ^ item_ff.timestamp[63:32];
            end
            count_in = count_ff + 32'd1;
            words_in[12] = count_ff + 32'd1;
         end
         ST_ROUND: begin
            words_in[ia] = qa;
            words_in[ib] = qb;
            words_in[ic] = qc;
            words_in[id] = qd;
            round_in = round_ff + RW'(1);
         end
         ST_EMIT: begin
            if (rsp_ready) emit_in = emit_ff + 6'd1;
         end
         ST_FOLD: begin
            words_in[step_ff] = words_ff[step_ff] ^ pool_ff[step_ff];
            step_in = step_ff + 4'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 16; i++) words_ff[i] <= '0;
         for (int i = 0; i < 16; i++) pool_ff[i] <= '0;
         count_ff <= '0;
         seeded_ff <= 1'b0;
         pos_ff <= '0;
         writes_ff <= '0;
         interval_ff <= 9'd256;
         step_ff <= '0;
         round_ff <= '0;
         emit_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         words_ff <= words_in;
         pool_ff <= pool_in;
         count_ff <= count_in;
         seeded_ff <= seeded_in;
         pos_ff <= pos_in;
         writes_ff <= writes_in;
         step_ff <= step_in;
         round_ff <= round_in;
         emit_ff <= emit_in;
         total_ff <= total_in;
         if (csr_write) interval_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ts_ff <= ts_in;
   end
endmodule

// File: design/ccd_quarter.sv
// One ChaCha quarter round, the shared unit used by the round sequencer.
// Depends on ccd_pkg for the rotate helper.
module ccd_quarter
   import ccd_pkg::*;
(
   input  logic [31:0] a_in,
   input  logic [31:0] b_in,
   input  logic [31:0] c_in,
   input  logic [31:0] d_in,
   output logic [31:0] a_out,
   output logic [31:0] b_out,
   output logic [31:0] c_out,
   output logic [31:0] d_out
);
   logic [31:0] a1, b1, c1, d1, a2, d2, c2;

   always_comb begin
      a1 = a_in + b_in;
      d1 = rotl32(d_in ^ a1, 16);
      c1 = c_in + d1;
      b1 = rotl32(b_in ^ c1, 12);
      a2 = a1 + b1;
      d2 = rotl32(d1 ^ a2, 8);
      c2 = c1 + d2;
      a_out = a2;
      d_out = d2;
      c_out = c2;
      b_out = rotl32(b1 ^ c2, 7);
   end
endmodule

// File: design/ccd_checker.sv
// Port-level checker for the ChaCha generator, bound to the top level.
// Depends on ccd_pkg for the payload structs.
module ccd_checker
   import ccd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while emitting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last |=> !rsp_valid)
      else $error("item continues after last");
   a_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("gap inside generate");
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result right after accept");
endmodule

bind chacha_permutation_drbg_unit ccd_checker u_ccd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

// File: bench/chacha_permutation_drbg_unit_tb.sv
// Testbench for chacha_permutation_drbg_unit: a table of directed items, then random items.
// Every random byte is checked against a behavioral generator kept in the bench.
// Depends on ccd_pkg and the chacha_permutation_drbg_unit RTL.
module chacha_permutation_drbg_unit_tb;
   import ccd_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;
   localparam int TABLE_ROWS = 22;
   localparam int RANDOM_ITEMS = 250;
   localparam int DOUBLE_ROUNDS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [8:0] csr_data = '0;

   chacha_permutation_drbg_unit #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Generator state held by the bench.
   logic [31:0] words [16];
   logic [31:0] block_number;
   logic        is_seeded;
   logic [7:0]  pool [64];
   logic [5:0]  pool_index;
   logic [8:0]  write_count;
   logic [8:0]  interval;

   rsp_type pending_bytes [$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;

   function automatic logic [31:0] rot(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void mix_quarter(input int a, input int b, input int c, input int d);
      words[a] += words[b]; words[d] = rot(words[d] ^ words[a], 16);
      words[c] += words[d]; words[b] = rot(words[b] ^ words[c], 12);
      words[a] += words[b]; words[d] = rot(words[d] ^ words[a], 8);
      words[c] += words[d]; words[b] = rot(words[b] ^ words[c], 7);
   endfunction

   function automatic void load_seed(input logic [63:0] ts, input logic [31:0] ticks);
      logic [63:0] mix;
      words[0] = SIGMA0; words[1] = SIGMA1; words[2] = SIGMA2; words[3] = SIGMA3;
      for (int i = 4; i < 16; i++) begin
         mix = ts ^ {ticks, 32'h0};
         mix += {32'h0, 32'(i) * GOLDEN};
         words[i] = mix[31:0] ^ mix[63:32];
         ts ^= (mix << 13) | (mix >> 51);
      end
      block_number = 1;
      is_seeded = 1'b1;
      for (int i = 0; i < 64; i++) pool[i] = (i < 8) ? ts[i*8 +: 8] : 8'h00;
      pool_index = 0;
      write_count = 0;
   endfunction

   function automatic void clear_generator();
      for (int i = 0; i < 16; i++) words[i] = '0;
      for (int i = 0; i < 64; i++) pool[i] = '0;
      block_number = 0; is_seeded = 0; pool_index = 0; write_count = 0;
      interval = 9'd256;
   endfunction

   function automatic void apply_item(input req_type item);
      int count;
      rsp_type r;
      case (item.cmd)
         CMD_SEED: load_seed(item.timestamp, item.tick_count);
         CMD_ENTROPY: begin
            pool[pool_index] ^= item.entropy_byte;
            pool_index++;
            if (item.last_entropy) begin
               write_count++;
               if (write_count >= interval) begin
                  for (int i = 0; i < 16; i++)
                     words[i] ^= {pool[4*i+3], pool[4*i+2], pool[4*i+1], pool[4*i]};
                  write_count = 0;
               end
            end
         end
         CMD_GENERATE: begin
            count = item.byte_count;
            if (count != 0) begin
               if (count > 64) count = 64;
               if (!is_seeded) load_seed(item.timestamp, item.tick_count);
               if (item.fresh_request) begin
                  words[12] ^= item.timestamp[31:0];
                  words[13] ^= item.timestamp[63:32];
               end
               block_number++;
               words[12] = block_number;
               for (int d = 0; d < DOUBLE_ROUNDS; d++) begin
                  mix_quarter(0, 4, 8, 12); mix_quarter(1, 5, 9, 13);
                  mix_quarter(2, 6, 10, 14); mix_quarter(3, 7, 11, 15);
                  mix_quarter(0, 5, 10, 15); mix_quarter(1, 6, 11, 12);
                  mix_quarter(2, 7, 8, 13); mix_quarter(3, 4, 9, 14);
               end
               for (int k = 0; k < count; k++) begin
                  r.random_byte = words[k/4][(k%4)*8 +: 8];
                  r.last = (k + 1 == count);
                  pending_bytes.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch("unexpected byte", 32'(rsp_data), 0);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_data.random_byte !== want.random_byte)
                  report_mismatch("random_byte", 32'(rsp_data.random_byte),
                                  32'(want.random_byte));
               if (rsp_data.last !== want.last)
                  report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("chacha_permutation_drbg_unit_tb: errors");
         $finish;
      end
   end

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      apply_item(item);
   endtask

   task automatic write_interval(input logic [8:0] value);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      interval = value;
   endtask

   function automatic req_type random_item();
      req_type item;
      int pick;
      item = '0;
      item.timestamp = {$urandom, $urandom};
      item.tick_count = $urandom;
      item.entropy_byte = 8'($urandom_range(255));
      item.last_entropy = ($urandom_range(3) == 0);
      item.fresh_request = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 5) item.cmd = CMD_SEED;
      else if (pick < 55) item.cmd = CMD_ENTROPY;
      else if (pick < 97) item.cmd = CMD_GENERATE;
      else item.cmd = CMD_UNUSED;
      pick = $urandom_range(9);
      item.byte_count = (pick == 0) ? 7'($urandom_range(127)) :
                        (pick == 1) ? 7'd64 : 7'($urandom_range(1, 16));
      return item;
   endfunction

   req_type stimulus_table [TABLE_ROWS];
   logic    table_checked [TABLE_ROWS];

   function automatic req_type make_row(input cmd_type c, input logic [63:0] ts,
      input logic [31:0] tk, input logic [7:0] eb, input logic el,
      input logic [6:0] bc, input logic fr);
      req_type r;
      r.cmd = c; r.timestamp = ts; r.tick_count = tk; r.entropy_byte = eb;
      r.last_entropy = el; r.byte_count = bc; r.fresh_request = fr;
      return r;
   endfunction

   initial begin
      clear_generator();
      // Zero count before any seed; then implicit seed with extremes.
      stimulus_table[0] = make_row(CMD_GENERATE, '1, '1, 8'h00, 1'b0, 7'd0, 1'b1);
      stimulus_table[1] = make_row(CMD_UNUSED, '1, '1, 8'hFF, 1'b1, 7'd64, 1'b1);
      stimulus_table[2] = make_row(CMD_GENERATE, '0, '0, 8'h00, 1'b0, 7'd1, 1'b0);
      stimulus_table[3] = make_row(CMD_GENERATE, '1, '1, 8'h00, 1'b0, 7'd64, 1'b1);
      stimulus_table[4] = make_row(CMD_SEED, '1, '1, 8'h00, 1'b0, 7'd0, 1'b0);
      stimulus_table[5] = make_row(CMD_ENTROPY, '0, '0, 8'hFF, 1'b0, 7'd0, 1'b0);
      stimulus_table[6] = make_row(CMD_ENTROPY, '0, '0, 8'hA5, 1'b1, 7'd0, 1'b0);
      stimulus_table[7] = make_row(CMD_GENERATE, 64'h0123456789ABCDEF, 32'h5A5A5A5A,
                                   8'h00, 1'b0, 7'd127, 1'b1);
      stimulus_table[8] = make_row(CMD_SEED, '0, '0, 8'h00, 1'b0, 7'd0, 1'b0);
      stimulus_table[9] = make_row(CMD_GENERATE, '0, '0, 8'h00, 1'b0, 7'd65, 1'b0);
      stimulus_table[10] = make_row(CMD_ENTROPY, '1, '1, 8'h01, 1'b1, 7'd127, 1'b1);
      stimulus_table[11] = make_row(CMD_ENTROPY, '0, '0, 8'h80, 1'b1, 7'd0, 1'b0);
      stimulus_table[12] = make_row(CMD_GENERATE, '1, '0, 8'h00, 1'b0, 7'd4, 1'b1);
      stimulus_table[13] = make_row(CMD_GENERATE, '0, '1, 8'h00, 1'b0, 7'd63, 1'b0);
      stimulus_table[14] = make_row(CMD_GENERATE, '0, '0, 8'h00, 1'b0, 7'd0, 1'b1);
      stimulus_table[15] = make_row(CMD_SEED, 64'h8000000000000001, 32'h80000001,
                                    8'h00, 1'b0, 7'd0, 1'b0);
      for (int i = 16; i < TABLE_ROWS; i++)
         stimulus_table[i] = make_row(CMD_ENTROPY, '0, '0, 8'(i * 37), 1'(i % 2),
                                      7'd0, 1'b0);
      for (int i = 0; i < TABLE_ROWS; i++) table_checked[i] = 1'b0;
      // Rows whose outcome is no bytes at all.
      table_checked[0] = 1'b1;
      table_checked[1] = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < TABLE_ROWS; i++) begin
         if (i == 10) write_interval(9'd1);
         send_item(stimulus_table[i]);
         if (table_checked[i] && pending_bytes.size() != 0)
            report_mismatch("bytes from a silent item", pending_bytes.size(), 0);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 15 : (phase == 1) ? 80 : 0;
         recv_idle = (phase == 0) ? 80 : (phase == 1) ? 15 : 0;
         write_interval((phase == 0) ? 9'd0 : (phase == 1) ? 9'd256 :
                        9'($urandom_range(2, 6)));
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_item(random_item());
      end
      write_interval(9'd511);
      for (int n = 0; n < 8; n++) send_item(random_item());
      req_valid <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) $display("chacha_permutation_drbg_unit_tb: clean");
      else $display("chacha_permutation_drbg_unit_tb: errors");
      $finish;
   end

endmodule
